>>> src/sprc_pkg.sv
`default_nettype none
package sprc_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W      = $clog2(DEPTH);

	localparam logic [16:0] ONE16    = 17'h10000;
	localparam logic [31:0] HASH_MUL = 32'd214013;
	localparam logic [31:0] HASH_ADD = 32'd2531011;
	localparam logic [15:0] UNITY_GAIN = 16'd256;

	localparam logic [2:0] CFG_GLOBAL_ALPHA   = 3'd0;
	localparam logic [2:0] CFG_BRIGHTNESS     = 3'd1;
	localparam logic [2:0] CFG_GLOBAL_TINT    = 3'd2;
	localparam logic [2:0] CFG_PERSIST_EN     = 3'd3;
	localparam logic [2:0] CFG_PERSIST_COLOR  = 3'd4;
	localparam logic [2:0] CFG_DITHER_THRESH  = 3'd5;
	localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd6;
	localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd7;

	typedef logic [16:0] ratio_t;

	// low byte of (a*r + b*(1-r)) >> 16, r in 1.16 with 1.0 = 65536
	function automatic logic [7:0] mix8(input logic [15:0] a, input logic [15:0] b,
		input ratio_t r);
		logic [33:0] s;
		s = 34'(a) * 34'(r) + 34'(b) * 34'(ONE16 - r);
		return s[23:16];
	endfunction

	// (a << 16) / 255 == a*257, plus one at a == 255
	function automatic ratio_t ratio255(input logic [7:0] a);
		return 17'(a) * 17'd257 + 17'(a == 8'hff);
	endfunction

	function automatic ratio_t dither_pick(input ratio_t r, input logic [15:0] h);
		logic [32:0] lhs;
		logic [32:0] rhs;
		lhs = {r, 16'h0000} - 33'(r);
		rhs = {1'b0, h, 16'h0000};
		return (lhs < rhs) ? 17'd0 : ONE16;
	endfunction

	function automatic logic [15:0] brighten(input logic [7:0] c, input logic [15:0] g);
		logic [23:0] p;
		p = 24'(c) * 24'(g);
		return p[23:8];
	endfunction

	// low byte of the brightened channel
	function automatic logic [7:0] brighten8(input logic [7:0] c, input logic [15:0] g);
		logic [23:0] p;
		p = 24'(c) * 24'(g);
		return p[15:8];
	endfunction

endpackage
`default_nettype wire

>>> src/sprite_pixel_compositor.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  src_color .. bg_offset (one pixel)
// out       source     out_valid/out_stall written .. drawn_count (one result)
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// One pixel at a time, stepped by the sequencer and the 24-step shared divider
// (tint merge ratio, persistence ratio) around the registered reads of the frame
// and persistence memories.
// After reset a clearing pass over all 65536 entries fills the frame store with ones
// and the persistence store with zeros; in_stall stays high during it.
// A finished result waits in the output register; the next pixel is taken
// meanwhile and holds in its final step until the output register frees.
module sprite_pixel_compositor (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [31:0]            src_color,
	input  wire logic                   src_transparent,
	input  wire logic signed [10:0]     pos_x,
	input  wire logic signed [10:0]     pos_y,
	input  wire logic [31:0]            column_tint,
	input  wire logic                   column_tint_none,
	input  wire logic signed [10:0]     bg_offset,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        written,
	output logic [15:0]                 pixel_index,
	output logic [31:0]                 frame_color,
	output logic                        persist_written,
	output logic [31:0]                 persist_color,
	output logic [31:0]                 drawn_count,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [32:0]            cfg_data
);
	import sprc_pkg::*;

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_CHK   = 5'd2;
	localparam logic [4:0] ST_DIVT  = 5'd3;
	localparam logic [4:0] ST_TINT  = 5'd4;
	localparam logic [4:0] ST_COL   = 5'd5;
	localparam logic [4:0] ST_BRT   = 5'd6;
	localparam logic [4:0] ST_PB    = 5'd7;
	localparam logic [4:0] ST_ALPH  = 5'd8;
	localparam logic [4:0] ST_DTH   = 5'd9;
	localparam logic [4:0] ST_BLEND = 5'd10;
	localparam logic [4:0] ST_WR    = 5'd11;
	localparam logic [4:0] ST_PCHK  = 5'd12;
	localparam logic [4:0] ST_PDIV  = 5'd13;
	localparam logic [4:0] ST_PDTH  = 5'd14;
	localparam logic [4:0] ST_PMIX  = 5'd15;
	localparam logic [4:0] ST_DONE  = 5'd16;

	localparam logic [4:0] DIV_LAST = 5'd23;

	// frame and persistence stores
	logic [31:0] frame_mem [DEPTH];
	logic [31:0] persist_mem [DEPTH];
	logic             fs_we, ps_we;
	logic [IDX_W-1:0] fs_waddr, fs_raddr, ps_addr;
	logic [31:0]      fs_wdata, ps_wdata, fs_rdata, ps_rdata;

	// control
	logic [4:0]       state_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [31:0]      drawn_q;
	logic             out_valid_q;

	// configuration
	logic [7:0]  ga_q;
	logic [15:0] gain_q;
	logic [32:0] gt_q;
	logic        pe_q;
	logic [32:0] gpc_q;
	logic [15:0] dt_q;
	logic [8:0]  fw_q, fh_q;

	// pixel and work registers
	logic [31:0] src_q, ctint_q;
	logic        transp_q, cnone_q;
	logic [10:0] px_q, py_q, bgoff_q;
	logic [IDX_W-1:0] idx_q;
	logic [17:0] wh_q;
	logic [31:0] tint_q;
	logic        tnone_q, mixt_q;
	logic [31:0] pcol_q;
	logic [15:0] hash_q;
	logic [7:0]  c8_q [3];
	logic [15:0] crb_q [3];
	logic [15:0] prod_q;
	logic [7:0]  ca_q;
	ratio_t      r_q;
	logic        dth_q, bgv_q;
	logic [31:0] color_q;
	logic [31:0] pval_q;
	logic        pw_q, wr_q;

	// divider
	logic [23:0] div_quo_q;
	logic [9:0]  div_rem_q;
	logic [8:0]  div_den_q;
	logic [4:0]  div_cnt_q;

	// output register
	logic        o_written_q, o_pw_q;
	logic [15:0] o_idx_q;
	logic [31:0] o_color_q, o_pcol_q, o_drawn_q;

	// combinational helpers
	logic [8:0]  w_c, h_c;
	logic        skip_c, need_div_c, proc_c;
	logic [31:0] tint_c;
	logic        tnone_c;
	logic [7:0]  ta_c;
	ratio_t      rt_c, ra_c, rd_c, rp_c;
	logic [17:0] bi_c;
	logic        bgv_c;
	logic [9:0]  div_step_c;
	logic        div_bit_c;
	logic [31:0] bg_c, cur_c;
	logic [7:0]  pa_c, cura_c;
	logic [31:0] pc_c;
	logic        accept_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_c  = in_valid && !in_stall;

	assign w_c = (fw_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : fw_q;
	assign h_c = (fh_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : fh_q;

	assign skip_c = (ga_q == 8'd0) || transp_q || (src_q[31:24] == 8'd0)
		|| px_q[10] || py_q[10]
		|| ({1'b0, px_q[9:0]} >= {2'b00, w_c})
		|| ({1'b0, py_q[9:0]} >= {2'b00, h_c});

	// merge global and column tint
	always_comb begin
		tint_c     = gt_q[31:0];
		tnone_c    = 1'b0;
		need_div_c = 1'b0;
		if (gt_q[32]) begin
			tint_c  = ctint_q;
			tnone_c = cnone_q;
		end else if (!cnone_q && ctint_q[31:24] != 8'd0) begin
			if (gt_q[31:24] == 8'd0) begin
				tint_c = ctint_q;
			end else begin
				need_div_c = 1'b1;
			end
		end
	end

	assign proc_c = (src_q[31:24] != 8'hff) || (ga_q != 8'hff) || (gain_q != UNITY_GAIN)
		|| !tnone_q;
	assign ta_c   = tnone_q ? 8'd0 : tint_q[31:24];
	assign rt_c   = ratio255(ta_c);
	assign ra_c   = ratio255(ca_q);
	assign rd_c   = dth_q ? dither_pick(r_q, hash_q) : r_q;

	assign bi_c  = $signed({2'b00, idx_q}) + $signed({{7{bgoff_q[10]}}, bgoff_q});
	assign bgv_c = !bi_c[17] && (bi_c < wh_q);

	assign div_step_c = {div_rem_q[8:0], div_quo_q[23]};
	assign div_bit_c  = (div_step_c >= {1'b0, div_den_q});

	assign bg_c   = bgv_q ? fs_rdata : 32'd0;
	assign cur_c  = ps_rdata;
	assign pa_c   = pcol_q[31:24];
	assign cura_c = cur_c[31:24];
	assign rp_c   = ((dt_q != 16'd0) && (div_quo_q[16:0] <= {1'b0, dt_q}))
		? dither_pick(div_quo_q[16:0], hash_q) : div_quo_q[16:0];

	// persistence colour after the pixel's own processing
	always_comb begin
		logic [31:0] p;
		p = gpc_q[32] ? {ca_q, crb_q[0][7:0], crb_q[1][7:0], crb_q[2][7:0]} : pcol_q;
		pc_c = p;
		if (gain_q != UNITY_GAIN) begin
			pc_c = {p[31:24], brighten8(p[23:16], gain_q),
				brighten8(p[15:8], gain_q), brighten8(p[7:0], gain_q)};
		end
	end

	// memory port control
	always_comb begin
		fs_we    = 1'b0;
		ps_we    = 1'b0;
		fs_waddr = idx_q;
		fs_wdata = color_q;
		fs_raddr = bi_c[IDX_W-1:0];
		ps_addr  = idx_q;
		ps_wdata = pcol_q;
		case (state_q)
			ST_CLR: begin
				fs_we    = 1'b1;
				ps_we    = 1'b1;
				fs_waddr = clr_addr_q;
				fs_wdata = 32'hffff_ffff;
				ps_addr  = clr_addr_q;
				ps_wdata = 32'd0;
			end
			ST_WR: begin
				fs_we = 1'b1;
			end
			ST_PCHK: begin
				ps_we = pe_q && (src_q[31:24] > 8'd1) && (cura_c <= 8'd2);
			end
			ST_PMIX: begin
				ps_we = (r_q != 17'd0);
				if (r_q != ONE16) begin
					ps_wdata = {((pa_c > pval_q[31:24]) ? pa_c : pval_q[31:24]),
						mix8({8'd0, pcol_q[23:16]}, {8'd0, pval_q[23:16]}, r_q),
						mix8({8'd0, pcol_q[15:8]}, {8'd0, pval_q[15:8]}, r_q),
						mix8({8'd0, pcol_q[7:0]}, {8'd0, pval_q[7:0]}, r_q)};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			frame_mem[fs_waddr] <= fs_wdata;
		end
		fs_rdata <= frame_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			persist_mem[ps_addr] <= ps_wdata;
		end
		ps_rdata <= persist_mem[ps_addr];
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			drawn_q     <= 32'd0;
			out_valid_q <= 1'b0;
			ga_q        <= 8'd255;
			gain_q      <= UNITY_GAIN;
			gt_q        <= 33'h1_0000_0000;
			pe_q        <= 1'b0;
			gpc_q       <= 33'h1_0000_0000;
			dt_q        <= 16'd0;
			fw_q        <= 9'd256;
			fh_q        <= 9'd256;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GLOBAL_ALPHA:  ga_q   <= cfg_data[7:0];
					CFG_BRIGHTNESS:    gain_q <= cfg_data[15:0];
					CFG_GLOBAL_TINT:   gt_q   <= cfg_data;
					CFG_PERSIST_EN:    pe_q   <= cfg_data[0];
					CFG_PERSIST_COLOR: gpc_q  <= cfg_data;
					CFG_DITHER_THRESH: dt_q   <= cfg_data[15:0];
					CFG_FRAME_WIDTH:   fw_q   <= cfg_data[8:0];
					CFG_FRAME_HEIGHT:  fh_q   <= cfg_data[8:0];
					default: begin
					end
				endcase
			end
			// load a finished result, or drop the one just taken
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IDX_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept_c) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (skip_c) begin
						state_q <= ST_DONE;
					end else if (need_div_c) begin
						state_q <= ST_DIVT;
					end else begin
						state_q <= ST_TINT;
					end
				end
				ST_DIVT: begin
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_TINT;
					end
				end
				ST_TINT: state_q <= ST_COL;
				ST_COL:  state_q <= proc_c ? ST_BRT : ST_WR;
				ST_BRT:  state_q <= ST_PB;
				ST_PB:   state_q <= ST_ALPH;
				ST_ALPH: state_q <= (ca_q != 8'hff) ? ST_DTH : ST_WR;
				ST_DTH: begin
					// a pixel dithered away with no background offset is dropped
					if (dth_q && rd_c == 17'd0 && bgoff_q == 11'd0) begin
						state_q <= ST_DONE;
					end else if (rd_c < ONE16) begin
						state_q <= ST_BLEND;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_BLEND: state_q <= ST_WR;
				ST_WR: begin
					drawn_q <= drawn_q + 32'd1;
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					if (pe_q && (src_q[31:24] > 8'd1) && (cura_c > 8'd2)) begin
						state_q <= ST_PDIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PDIV: begin
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_PDTH;
					end
				end
				ST_PDTH: state_q <= ST_PMIX;
				ST_PMIX: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept_c) begin
			src_q    <= src_color;
			transp_q <= src_transparent;
			px_q     <= pos_x;
			py_q     <= pos_y;
			ctint_q  <= column_tint;
			cnone_q  <= column_tint_none;
			bgoff_q  <= bg_offset;
		end
		if (state_q == ST_DIVT || state_q == ST_PDIV) begin
			div_rem_q <= div_bit_c ? (div_step_c - {1'b0, div_den_q}) : div_step_c;
			div_quo_q <= {div_quo_q[22:0], div_bit_c};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		case (state_q)
			ST_CHK: begin
				idx_q   <= IDX_W'(19'(py_q[9:0]) * 19'(w_c) + 19'(px_q[9:0]));
				wh_q    <= 18'(w_c) * 18'(h_c);
				tint_q  <= tint_c;
				tnone_q <= tnone_c;
				mixt_q  <= need_div_c;
				pcol_q  <= gpc_q[32] ? src_q : gpc_q[31:0];
				wr_q    <= 1'b0;
				pw_q    <= 1'b0;
				pval_q  <= 32'd0;
				color_q <= 32'd0;
				// start tint merge ratio: ga / (ga + ca)
				div_quo_q <= {gt_q[31:24], 16'h0000};
				div_rem_q <= 10'd0;
				div_den_q <= 9'(gt_q[31:24]) + 9'(ctint_q[31:24]);
				div_cnt_q <= 5'd0;
			end
			ST_TINT: begin
				hash_q <= 16'(32'(idx_q) * HASH_MUL + HASH_ADD);
				if (mixt_q) begin
					tint_q <= {
						mix8({8'd0, tint_q[31:24]}, {8'd0, ctint_q[31:24]}, div_quo_q[16:0]),
						mix8({8'd0, tint_q[23:16]}, {8'd0, ctint_q[23:16]}, div_quo_q[16:0]),
						mix8({8'd0, tint_q[15:8]}, {8'd0, ctint_q[15:8]}, div_quo_q[16:0]),
						mix8({8'd0, tint_q[7:0]}, {8'd0, ctint_q[7:0]}, div_quo_q[16:0])};
				end
			end
			ST_COL: begin
				color_q <= src_q;
				prod_q  <= 16'(ga_q) * 16'(src_q[31:24]);
				for (int i = 0; i < 3; i++) begin
					c8_q[i] <= (ta_c != 8'd0)
						? mix8({8'd0, tint_q[23-8*i -: 8]}, {8'd0, src_q[23-8*i -: 8]}, rt_c)
						: src_q[23-8*i -: 8];
				end
			end
			ST_BRT: begin
				for (int i = 0; i < 3; i++) begin
					crb_q[i] <= brighten(c8_q[i], gain_q);
				end
				// x / 255 for x below 65535
				ca_q <= 8'((17'(prod_q) + 17'(prod_q[15:8]) + 17'd1) >> 8);
			end
			ST_PB: begin
				if (pe_q) begin
					pcol_q <= pc_c;
				end
			end
			ST_ALPH: begin
				r_q     <= ra_c;
				dth_q   <= (dt_q != 16'd0) && (ra_c <= {1'b0, dt_q});
				color_q <= {8'hff, crb_q[0][7:0], crb_q[1][7:0], crb_q[2][7:0]};
			end
			ST_DTH: begin
				r_q   <= rd_c;
				bgv_q <= bgv_c;
			end
			ST_BLEND: begin
				for (int i = 0; i < 3; i++) begin
					color_q[23-8*i -: 8] <= (r_q == 17'd0) ? bg_c[23-8*i -: 8]
						: mix8(crb_q[i], {8'd0, bg_c[23-8*i -: 8]}, r_q);
				end
			end
			ST_WR: begin
				wr_q <= 1'b1;
			end
			ST_PCHK: begin
				if (pe_q && (src_q[31:24] > 8'd1) && (cura_c <= 8'd2)) begin
					pval_q <= pcol_q;
					pw_q   <= 1'b1;
				end else begin
					pval_q <= cur_c;
				end
				// start persistence ratio: pa / (pa + cura)
				div_quo_q <= {pa_c, 16'h0000};
				div_rem_q <= 10'd0;
				div_den_q <= 9'(pa_c) + 9'(cura_c);
				div_cnt_q <= 5'd0;
			end
			ST_PDTH: begin
				r_q <= rp_c;
			end
			ST_PMIX: begin
				if (r_q != 17'd0) begin
					pval_q <= ps_wdata;
					pw_q   <= 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					o_written_q <= wr_q;
					o_idx_q     <= wr_q ? 16'(idx_q) : 16'd0;
					o_color_q   <= wr_q ? color_q : 32'd0;
					o_pw_q      <= wr_q && pw_q;
					o_pcol_q    <= wr_q ? pval_q : 32'd0;
					o_drawn_q   <= drawn_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign written         = o_written_q;
	assign pixel_index     = o_idx_q;
	assign frame_color     = o_color_q;
	assign persist_written = o_pw_q;
	assign persist_color   = o_pcol_q;
	assign drawn_count     = o_drawn_q;

	a_fs_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		fs_we |-> (state_q == ST_WR || state_q == ST_CLR))
		else $error("frame store written outside write or clear step");

	a_drawn_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |=> drawn_q == $past(drawn_q) + 32'd1)
		else $error("drawn count did not advance on frame write");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVT || state_q == ST_PDIV) |-> div_cnt_q <= DIV_LAST)
		else $error("divider ran past its last step");

	a_ps_write_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(ps_we && state_q != ST_CLR) |-> pe_q)
		else $error("persistence store written with persistence disabled");

endmodule
`default_nettype wire

>>> tb/sprite_pixel_compositor_tb.sv
`timescale 1ns / 1ps
module sprite_pixel_compositor_tb;
	import sprc_pkg::*;

	typedef struct {
		logic [31:0]        color;
		logic               transparent;
		logic signed [10:0] x;
		logic signed [10:0] y;
		logic [31:0]        ctint;
		logic               ctint_none;
		logic signed [10:0] bg_off;
	} sprite_pixel_t;

	typedef struct {
		logic        written;
		logic [15:0] index;
		logic [31:0] frame;
		logic        pwritten;
		logic [31:0] pcolor;
		logic [31:0] count;
	} pixel_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [31:0]        src_color = '0;
	logic               src_transparent = 1'b0;
	logic signed [10:0] pos_x = '0;
	logic signed [10:0] pos_y = '0;
	logic [31:0]        column_tint = '0;
	logic               column_tint_none = 1'b0;
	logic signed [10:0] bg_offset = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               written;
	logic [15:0]        pixel_index;
	logic [31:0]        frame_color;
	logic               persist_written;
	logic [31:0]        persist_color;
	logic [31:0]        drawn_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [32:0]        cfg_data = '0;

	always #4 clk = ~clk;

	sprite_pixel_compositor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.src_color(src_color), .src_transparent(src_transparent),
		.pos_x(pos_x), .pos_y(pos_y),
		.column_tint(column_tint), .column_tint_none(column_tint_none),
		.bg_offset(bg_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.written(written), .pixel_index(pixel_index), .frame_color(frame_color),
		.persist_written(persist_written), .persist_color(persist_color),
		.drawn_count(drawn_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block's state and registers
	logic [31:0] frame_mirror [0:DEPTH-1];
	logic [31:0] persist_mirror [0:DEPTH-1];
	logic [31:0] drawn_mirror;
	logic [7:0]  m_alpha;
	logic [15:0] m_gain;
	logic [32:0] m_tint;
	logic        m_persist_en;
	logic [32:0] m_persist_color;
	logic [15:0] m_dither;
	logic [8:0]  m_width;
	logic [8:0]  m_height;

	pixel_outcome_t pending_results[$];
	int unsigned    errors = 0;
	int unsigned    send_gap_pct = 0;  // chance of an idle burst after a pixel
	int unsigned    stall_pct = 0;     // chance of a stall burst on the result side
	bit             quiet_tail = 0;
	int unsigned    stall_left = 0;

	function automatic longint unsigned ch(longint unsigned c, int sh);
		return (c >> sh) & 64'hff;
	endfunction

	function automatic longint unsigned blend16(longint unsigned a, longint unsigned b,
		longint unsigned r);
		return (a * r + b * (64'd65536 - r)) >> 16;
	endfunction

	function automatic longint unsigned dither_decide(longint unsigned r,
		longint unsigned idx);
		longint unsigned hv;
		hv = (64'd214013 * idx + 64'd2531011) & 64'hffff;
		return (r * 64'hffff < hv * 64'd65536) ? 64'd0 : 64'd65536;
	endfunction

	// Compute the outcome of one pixel and advance the shadow state
	function automatic pixel_outcome_t composite_pixel(sprite_pixel_t p);
		pixel_outcome_t  res;
		longint          px, py, bo, bi;
		longint unsigned w, h, alpha, color, pcol, idx, tint, cr, cg, cb;
		longint unsigned ta, ca, r, bg, ga, cal, cur, cura, pa, na, src, ct;
		bit              tnone;
		src = p.color;
		ct = p.ctint;
		px = p.x;
		py = p.y;
		bo = p.bg_off;
		w = (m_width > MAX_WIDTH) ? MAX_WIDTH : m_width;
		h = (m_height > MAX_HEIGHT) ? MAX_HEIGHT : m_height;
		alpha = ch(src, 24);
		color = src;
		res = '{1'b0, 16'h0, 32'h0, 1'b0, 32'h0, drawn_mirror};
		if (m_alpha == 0 || p.transparent || alpha == 0) return res;
		if (px < 0 || py < 0 || px >= longint'(w) || py >= longint'(h)) return res;

		// merge the global tint with the column tint
		tnone = m_tint[32];
		tint = m_tint[31:0];
		if (tnone) begin
			tnone = p.ctint_none;
			tint = ct;
		end else if (!p.ctint_none && ch(ct, 24) != 0) begin
			ga = ch(tint, 24);
			cal = ch(ct, 24);
			if (ga == 0) begin
				tint = ct;
			end else begin
				r = (ga << 16) / (ga + cal);
				tint = (blend16(ga, cal, r) << 24)
					| (blend16(ch(tint, 16), ch(ct, 16), r) << 16)
					| (blend16(ch(tint, 8), ch(ct, 8), r) << 8)
					| blend16(ch(tint, 0), ch(ct, 0), r);
			end
		end

		pcol = m_persist_color[32] ? src : longint'(m_persist_color[31:0]);
		idx = longint'(py) * w + longint'(px);

		if (alpha < 255 || m_alpha < 255 || m_gain != 256 || !tnone) begin
			cr = ch(src, 16);
			cg = ch(src, 8);
			cb = ch(src, 0);
			ta = tnone ? 0 : ch(tint, 24);
			ca = 255;
			if (ta > 0) begin
				r = (ta << 16) / 255;
				cr = blend16(ch(tint, 16), cr, r);
				cg = blend16(ch(tint, 8), cg, r);
				cb = blend16(ch(tint, 0), cb, r);
			end
			cr = (cr * m_gain) >> 8;
			cg = (cg * m_gain) >> 8;
			cb = (cb * m_gain) >> 8;
			if (m_alpha < 255 || alpha < 255) ca = (m_alpha * alpha) / 255;
			if (m_persist_en) begin
				if (m_persist_color[32])
					pcol = (ca << 24) | ((cr & 255) << 16) | ((cg & 255) << 8) | (cb & 255);
				// the persistence colour gets the gain too, a second time when taken from the channels
				if (m_gain != 256)
					pcol = (ch(pcol, 24) << 24)
						| ((((ch(pcol, 16) * m_gain) >> 8) & 255) << 16)
						| ((((ch(pcol, 8) * m_gain) >> 8) & 255) << 8)
						| (((ch(pcol, 0) * m_gain) >> 8) & 255);
			end
			if (ca < 255) begin
				r = (ca << 16) / 255;
				if (m_dither > 0 && r <= m_dither) begin
					r = dither_decide(r, idx);
					if (r == 0 && bo == 0) return res;
				end
				if (r < 65536) begin
					bi = longint'(idx) + bo;
					bg = 0;
					if (bi >= 0 && bi < longint'(w * h)) bg = frame_mirror[bi];
					if (r == 0) begin
						cr = ch(bg, 16);
						cg = ch(bg, 8);
						cb = ch(bg, 0);
					end else begin
						cr = blend16(cr, ch(bg, 16), r);
						cg = blend16(cg, ch(bg, 8), r);
						cb = blend16(cb, ch(bg, 0), r);
					end
				end
			end
			color = 64'hff000000 | ((cr & 255) << 16) | ((cg & 255) << 8) | (cb & 255);
		end

		frame_mirror[idx] = color[31:0];
		drawn_mirror++;
		res.written = 1'b1;
		res.index = idx[15:0];
		res.frame = color[31:0];
		res.count = drawn_mirror;

		if (m_persist_en && alpha > 1) begin
			cur = persist_mirror[idx];
			cura = ch(cur, 24);
			if (cura <= 2) begin
				persist_mirror[idx] = pcol[31:0];
				res.pwritten = 1'b1;
			end else begin
				pa = ch(pcol, 24);
				r = (pa << 16) / (pa + cura);
				if (m_dither > 0 && r <= m_dither) r = dither_decide(r, idx);
				if (r == 65536) begin
					persist_mirror[idx] = pcol[31:0];
					res.pwritten = 1'b1;
				end else if (r > 0) begin
					na = (pa > cura) ? pa : cura;
					persist_mirror[idx] = ((na << 24)
						| ((blend16(ch(pcol, 16), ch(cur, 16), r) & 255) << 16)
						| ((blend16(ch(pcol, 8), ch(cur, 8), r) & 255) << 8)
						| (blend16(ch(pcol, 0), ch(cur, 0), r) & 255));
					res.pwritten = 1'b1;
				end
			end
		end
		res.pcolor = persist_mirror[idx];
		return res;
	endfunction

	// Result side: random stall bursts, none in the tail of the run
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic flag(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t ERROR %s: expected %h actual %h", $time, field, want, got);
		errors++;
	endtask

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		pixel_outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ERROR unexpected result: expected none actual index %h",
					$time, pixel_index);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (written !== e.written) flag("written", e.written, written);
				if (pixel_index !== e.index) flag("pixel_index", e.index, pixel_index);
				if (frame_color !== e.frame) flag("frame_color", e.frame, frame_color);
				if (persist_written !== e.pwritten)
					flag("persist_written", e.pwritten, persist_written);
				if (persist_color !== e.pcolor)
					flag("persist_color", e.pcolor, persist_color);
				if (drawn_count !== e.count) flag("drawn_count", e.count, drawn_count);
			end
		end
	end

	// Present one pixel, hold it until taken, then maybe idle a burst
	task automatic send_pixel(sprite_pixel_t p);
		src_color <= p.color;
		src_transparent <= p.transparent;
		pos_x <= p.x;
		pos_y <= p.y;
		column_tint <= p.ctint;
		column_tint_none <= p.ctint_none;
		bg_offset <= p.bg_off;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(composite_pixel(p));
		if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [32:0] value);
		cfg_index <= index;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_GLOBAL_ALPHA:  m_alpha = value[7:0];
			CFG_BRIGHTNESS:    m_gain = value[15:0];
			CFG_GLOBAL_TINT:   m_tint = value;
			CFG_PERSIST_EN:    m_persist_en = value[0];
			CFG_PERSIST_COLOR: m_persist_color = value;
			CFG_DITHER_THRESH: m_dither = value[15:0];
			CFG_FRAME_WIDTH:   m_width = value[8:0];
			default:           m_height = value[8:0];
		endcase
	endtask

	task automatic configure(logic [7:0] ga, logic [15:0] gain, logic [32:0] tint,
		logic pen, logic [32:0] pcol, logic [15:0] dth, logic [8:0] fw, logic [8:0] fh);
		drain();
		write_reg(CFG_GLOBAL_ALPHA, 33'(ga));
		write_reg(CFG_BRIGHTNESS, 33'(gain));
		write_reg(CFG_GLOBAL_TINT, tint);
		write_reg(CFG_PERSIST_EN, 33'(pen));
		write_reg(CFG_PERSIST_COLOR, pcol);
		write_reg(CFG_DITHER_THRESH, 33'(dth));
		write_reg(CFG_FRAME_WIDTH, 33'(fw));
		write_reg(CFG_FRAME_HEIGHT, 33'(fh));
		cfg_valid <= 1'b0;
	endtask

	function automatic sprite_pixel_t mk(logic [31:0] c, logic tr, int x, int y,
		logic [31:0] ct, logic cn, int bo);
		sprite_pixel_t p;
		p = '{c, tr, 11'(x), 11'(y), ct, cn, 11'(bo)};
		return p;
	endfunction

	// Random pixel, mostly inside the frame so the stores see reuse
	function automatic sprite_pixel_t random_pixel();
		sprite_pixel_t p;
		int unsigned   sel;
		int unsigned   w, h;
		w = (m_width > MAX_WIDTH) ? MAX_WIDTH : ((m_width == 0) ? 1 : m_width);
		h = (m_height > MAX_HEIGHT) ? MAX_HEIGHT : ((m_height == 0) ? 1 : m_height);
		p.color = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 25) p.color[31:24] = 8'hff;
		else if (sel < 33) p.color[31:24] = 8'h00;
		else if (sel < 43) p.color[31:24] = 8'($urandom_range(1, 3));
		p.transparent = ($urandom_range(0, 99) < 8);
		if ($urandom_range(0, 99) < 85) begin
			p.x = 11'($urandom_range(0, w - 1));
			p.y = 11'($urandom_range(0, h - 1));
		end else begin
			p.x = 11'($urandom);
			p.y = 11'($urandom);
		end
		p.ctint = $urandom;
		if ($urandom_range(0, 3) == 0) p.ctint[31:24] = 8'h00;
		p.ctint_none = ($urandom_range(0, 99) < 40);
		sel = $urandom_range(0, 99);
		if (sel < 40) p.bg_off = '0;
		else if (sel < 80) p.bg_off = 11'($urandom_range(0, 16) - 8);
		else p.bg_off = 11'($urandom);
		return p;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_pixel(random_pixel());
	endtask

	task automatic random_setup();
		logic [32:0] tint, pcol;
		tint = {1'($urandom_range(0, 1)), 32'($urandom)};
		pcol = {1'($urandom_range(0, 1)), 32'($urandom)};
		configure(($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 254)) : 8'hff,
			($urandom_range(0, 1) == 0) ? 16'd256 : 16'($urandom_range(0, 1024)),
			tint, ($urandom_range(0, 3) != 0), pcol,
			($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom),
			9'($urandom_range(1, 16)), 9'($urandom_range(1, 12)));
	endtask

	// Test: field extremes, skip paths, background edges at reset, then tint and gain
	task automatic test_directed();
		send_gap_pct = 0;
		stall_pct = 0;
		send_pixel(mk(32'hff123456, 0, 0, 0, 32'h0, 1, 0));
		send_pixel(mk(32'hffabcdef, 0, 255, 255, 32'h0, 1, 0));
		send_pixel(mk(32'hff000000, 0, -1024, 5, 32'h0, 1, 0));
		send_pixel(mk(32'hff000000, 0, 5, 1023, 32'h0, 1, 0));
		send_pixel(mk(32'hffffffff, 1, 1, 1, 32'h0, 1, 0));
		send_pixel(mk(32'h00ffffff, 0, 1, 1, 32'h0, 1, 0));
		send_pixel(mk(32'h80102030, 0, 2, 0, 32'h0, 1, 0));
		send_pixel(mk(32'h80405060, 0, 0, 0, 32'h0, 1, -1));
		send_pixel(mk(32'h807f8f9f, 0, 3, 0, 32'h0, 1, 1023));
		send_pixel(mk(32'h40ffffff, 0, 4, 0, 32'h0, 1, -1024));
		send_pixel(mk(32'hff0000ff, 0, 5, 0, 32'h80ff0000, 0, 0));
		send_pixel(mk(32'hffffffff, 0, 6, 0, 32'hffffffff, 0, 0));
		// tint on, strong gain, fixed persistence colour, dithering everywhere
		configure(8'hff, 16'd1024, {1'b0, 32'h40008000}, 1'b1, {1'b0, 32'hc0112233},
			16'hffff, 9'd511, 9'd4);
		send_pixel(mk(32'hffffffff, 0, 255, 3, 32'h800000ff, 0, 0));
		send_pixel(mk(32'h02010203, 0, 1, 1, 32'h0, 1, 0));
		send_pixel(mk(32'h30808080, 0, 1, 1, 32'h0, 1, 1));
		send_pixel(mk(32'hc0808080, 0, 1, 1, 32'h00ffffff, 0, 0));
		send_pixel(mk(32'hff000000, 0, 0, 4, 32'h0, 1, 0));
		configure(8'hff, 16'd256, {1'b0, 32'h00ffffff}, 1'b1, {1'b1, 32'h0},
			16'h0, 9'd256, 9'd256);
		send_pixel(mk(32'hff445566, 0, 7, 7, 32'h90102030, 0, 0));
		send_pixel(mk(32'h90445566, 0, 7, 7, 32'h0, 1, 0));
		send_pixel(mk(32'h01445566, 0, 7, 7, 32'h0, 1, 0));
	endtask

	// Test: register extremes
	task automatic test_register_extremes();
		send_gap_pct = 30;
		stall_pct = 20;
		configure(8'h00, 16'd256, {1'b1, 32'h0}, 1'b1, {1'b1, 32'h0}, 16'h0, 9'd8, 9'd8);
		run_random(20);
		configure(8'hff, 16'hffff, {1'b0, 32'hffffffff}, 1'b1, {1'b0, 32'hffffffff},
			16'hffff, 9'd1, 9'd1);
		run_random(30);
		configure(8'h01, 16'h0, {1'b1, 32'hffffffff}, 1'b1, {1'b1, 32'hffffffff},
			16'h0001, 9'd256, 9'd511);
		run_random(30);
		configure(8'hff, 16'd256, {1'b1, 32'h0}, 1'b0, {1'b1, 32'h0}, 16'h0, 9'd16, 9'd0);
		run_random(20);
	endtask

	// Test: random settings on small frames so pixels overlap
	task automatic test_random_phases();
		for (int k = 0; k < 7; k++) begin
			send_gap_pct = (k % 3 == 2) ? 0 : 35;
			stall_pct = (k % 3 == 1) ? 0 : 25;
			random_setup();
			run_random(60);
			// hold off until every result is back, then carry on in the same setting
			drain();
			run_random(60);
		end
	endtask

	// Test: back-to-back traffic with no idling on either side
	task automatic test_quiet_tail();
		quiet_tail = 1;
		random_setup();
		run_random(100);
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			frame_mirror[i] = 32'hffffffff;
			persist_mirror[i] = 32'h0;
		end
		drawn_mirror = 0;
		m_alpha = 8'hff;
		m_gain = 16'd256;
		m_tint = {1'b1, 32'h0};
		m_persist_en = 1'b0;
		m_persist_color = {1'b1, 32'h0};
		m_dither = 16'h0;
		m_width = 9'd256;
		m_height = 9'd256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_phases();
		test_quiet_tail();
		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("%0t ERROR timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
